### rtl/core/ggc_pkg.sv
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared constants and sequencer states of the greedy graph colouring unit.
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VW           = $clog2(MAX_VERTICES);   // vertex index width
  localparam int NW           = VW + 1;                 // vertex count width
  localparam int EW           = $clog2(MAX_EDGES);      // edge index width
  localparam int ECW          = EW + 1;                 // edge count width
  localparam int DW           = ECW + 1;                // degree width
  localparam int EDGE_W       = 2 * VW;                 // stored endpoint pair

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_D_INIT,
    ST_D_RD,
    ST_D_EDGE,
    ST_D_A,
    ST_D_B,
    ST_S_INIT,
    ST_S_D0,
    ST_S_RD,
    ST_S_CMP,
    ST_W_INIT,
    ST_W_POP,
    ST_W_POPD,
    ST_W_RD,
    ST_W_EDGE,
    ST_C_ORD,
    ST_C_ORDD,
    ST_C_RD,
    ST_C_EDGE,
    ST_C_CB,
    ST_C_CA,
    ST_C_PICK,
    ST_O_RD,
    ST_O_LD,
    ST_O_WAIT
  } ggc_state_t;

endpackage

### rtl/core/ggc_ram.sv
// ----------------------------------------------------------------------------
// ggc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/greedy_graph_coloring_unit.sv
// ----------------------------------------------------------------------------
// greedy_graph_coloring_unit
// Loads an undirected graph edge by edge and colours it greedily.
// ----------------------------------------------------------------------------
// Usage: set cfg_vertex_count (1..64; 0 reads as 1, larger as 64) while idle,
// then send edges as in_ beats, one accepted per cycle while loading. A beat
// with edge_present low carries no edge; out-of-range edges and edges past
// the 256-entry store are dropped. The beat with in_last_item high starts
// colouring; in_stall stays high until every result has been taken.
// Results: one out_ beat per vertex, vertices 0..n-1 in order, last_vertex on
// the final one. After the last beat the sequencer clears the degree table,
// counts degrees by a sweep over the edge RAM, scans the degrees, runs up to
// two breadth-first walks (none for a regular graph) and picks colours, both
// again by edge sweeps, then sends the results. Each result waits in an
// output register while out_stall is high, and the sequencer holds meanwhile.
// Reset (synchronous, rst_n low): back to loading, edge count zero, vertex
// count 1. The edge store and degree table are not cleared; degrees are
// rebuilt from the stored edges when colouring starts.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [ggc_pkg::NW-1:0] cfg_vertex_count,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ggc_pkg::NW-1:0] in_first_end,
  input  logic [ggc_pkg::NW-1:0] in_second_end,
  input  logic                 in_edge_present,
  input  logic                 in_last_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ggc_pkg::VW-1:0] out_vertex,
  output logic [ggc_pkg::VW-1:0] out_color,
  output logic                 out_last_vertex
);
  import ggc_pkg::*;

  // Sequencer and counters
  ggc_state_t        state_r, state_nxt;
  logic [NW-1:0]     vcnt_r, vcnt_nxt;      // configured vertex count
  logic [ECW-1:0]    ecnt_r, ecnt_nxt;      // edges loaded
  logic [ECW-1:0]    e_r, e_nxt;            // edge sweep pointer
  logic [NW-1:0]     i_r, i_nxt;            // vertex loop counter
  logic [DW-1:0]     deg0_r, deg0_nxt;      // degree of vertex 0
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;  // visited marks
  logic [MAX_VERTICES-1:0] cvld_r, cvld_nxt; // vertex coloured
  logic              regular_r, regular_nxt;
  logic [VW-1:0]     umin_r, umin_nxt;
  logic [DW-1:0]     minv_r, minv_nxt;
  logic              walk2_r, walk2_nxt;
  logic              smart_r, smart_nxt;
  logic [NW-1:0]     head_r, head_nxt;
  logic [NW-1:0]     tail_r, tail_nxt;
  logic [NW-1:0]     reached_r, reached_nxt;
  logic [VW-1:0]     v_r, v_nxt;            // vertex being expanded / coloured
  logic [VW-1:0]     ea_r, ea_nxt;
  logic [VW-1:0]     eb_r, eb_nxt;
  logic              ev_r, ev_nxt;
  logic [MAX_VERTICES-1:0] used_r, used_nxt;
  logic [VW-1:0]     c_r, c_nxt;
  logic              cv_r;                  // colour read hit a coloured vertex
  logic              out_valid_r, out_valid_nxt;
  logic [VW-1:0]     out_vertex_r, out_vertex_nxt;
  logic [VW-1:0]     out_color_r, out_color_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic              e_we;
  logic [EW-1:0]     e_waddr, e_raddr;
  logic [EDGE_W-1:0] e_wdata, e_rdata;
  logic              q_we;
  logic [VW-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;
  logic              col_we;
  logic [VW-1:0]     col_waddr, col_raddr, col_wdata, col_rdata;
  logic              d_we;
  logic [VW-1:0]     d_waddr, d_raddr;
  logic [DW-1:0]     d_wdata, d_rdata;

  // Derived values
  logic [NW-1:0]     n_act;
  logic              in_acc;
  logic              in_ok;
  logic [VW-1:0]     ra, rb;
  logic              rvalid;

  assign n_act = (vcnt_r == '0) ? NW'(1) :
                 (vcnt_r > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vcnt_r;
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign in_ok    = in_edge_present && (in_first_end >= NW'(1)) && (in_first_end <= n_act)
                    && (in_second_end >= NW'(1)) && (in_second_end <= n_act)
                    && (ecnt_r < ECW'(MAX_EDGES));
  assign ra     = e_rdata[VW-1:0];
  assign rb     = e_rdata[EDGE_W-1:VW];
  assign rvalid = ({1'b0, ra} < n_act) && ({1'b0, rb} < n_act);

  ggc_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata)
  );
  ggc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );
  ggc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_colour_ram (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(col_wdata), .raddr(col_raddr),
    .rdata(col_rdata)
  );
  ggc_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree_ram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata)
  );

  // Store the edge as 0-based endpoints, second end in the upper half
  assign e_we    = in_acc && in_ok;
  assign e_waddr = ecnt_r[EW-1:0];
  assign e_wdata = {VW'(in_second_end - NW'(1)), VW'(in_first_end - NW'(1))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      vcnt_r      <= NW'(1);
      ecnt_r      <= '0;
      vis_r       <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      ecnt_r      <= ecnt_nxt;
      vis_r       <= vis_nxt;
      cvld_r      <= cvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    i_r          <= i_nxt;
    deg0_r       <= deg0_nxt;
    regular_r    <= regular_nxt;
    umin_r       <= umin_nxt;
    minv_r       <= minv_nxt;
    walk2_r      <= walk2_nxt;
    smart_r      <= smart_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    reached_r    <= reached_nxt;
    v_r          <= v_nxt;
    ea_r         <= ea_nxt;
    eb_r         <= eb_nxt;
    ev_r         <= ev_nxt;
    used_r       <= used_nxt;
    c_r          <= c_nxt;
    cv_r         <= cvld_r[col_raddr];
    out_vertex_r <= out_vertex_nxt;
    out_color_r  <= out_color_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    vcnt_nxt       = cfg_wr_en ? cfg_vertex_count : vcnt_r;
    ecnt_nxt       = ecnt_r;
    e_nxt          = e_r;
    i_nxt          = i_r;
    deg0_nxt       = deg0_r;
    vis_nxt        = vis_r;
    cvld_nxt       = cvld_r;
    regular_nxt    = regular_r;
    umin_nxt       = umin_r;
    minv_nxt       = minv_r;
    walk2_nxt      = walk2_r;
    smart_nxt      = smart_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    reached_nxt    = reached_r;
    v_nxt          = v_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    ev_nxt         = ev_r;
    used_nxt       = used_r;
    c_nxt          = c_r;
    out_valid_nxt  = out_valid_r;
    out_vertex_nxt = out_vertex_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    e_raddr        = e_r[EW-1:0];
    q_we           = 1'b0;
    q_waddr        = tail_r[VW-1:0];
    q_wdata        = '0;
    q_raddr        = head_r[VW-1:0];
    col_we         = 1'b0;
    col_waddr      = v_r;
    col_wdata      = c_r;
    col_raddr      = '0;
    d_we           = 1'b0;
    d_waddr        = ea_r;
    d_wdata        = '0;
    d_raddr        = i_r[VW-1:0];

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_ok) begin
            ecnt_nxt = ecnt_r + ECW'(1);
          end
          if (in_last_item) begin
            i_nxt     = '0;
            state_nxt = ST_D_INIT;
          end
        end
      end
      ST_D_INIT: begin
        // clear one degree entry per cycle over the active vertices
        d_we    = 1'b1;
        d_waddr = i_r[VW-1:0];
        d_wdata = '0;
        if (i_r + NW'(1) == n_act) begin
          cvld_nxt  = '0;
          e_nxt     = '0;
          state_nxt = ST_D_RD;
        end else begin
          i_nxt = i_r + NW'(1);
        end
      end
      ST_D_RD: begin
        if (e_r == ecnt_r) begin
          state_nxt = ST_S_INIT;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = ST_D_EDGE;
        end
      end
      ST_D_EDGE: begin
        // skip edges naming a vertex outside the current count
        ea_nxt = ra;
        eb_nxt = rb;
        if (rvalid) begin
          d_raddr   = ra;
          state_nxt = ST_D_A;
        end else begin
          state_nxt = ST_D_RD;
        end
      end
      ST_D_A: begin
        d_we      = 1'b1;
        d_waddr   = ea_r;
        d_wdata   = d_rdata + DW'(1);
        d_raddr   = eb_r;
        state_nxt = ST_D_B;
      end
      ST_D_B: begin
        // on a self-loop the read above missed the first increment: add two
        d_we      = 1'b1;
        d_waddr   = eb_r;
        d_wdata   = d_rdata + ((ea_r == eb_r) ? DW'(2) : DW'(1));
        state_nxt = ST_D_RD;
      end
      ST_S_INIT: begin
        d_raddr   = '0;
        state_nxt = ST_S_D0;
      end
      ST_S_D0: begin
        deg0_nxt    = d_rdata;
        minv_nxt    = d_rdata;
        umin_nxt    = '0;
        regular_nxt = 1'b1;
        i_nxt       = NW'(1);
        state_nxt   = ST_S_RD;
      end
      ST_S_RD: begin
        if (i_r >= n_act) begin
          if (regular_r) begin
            smart_nxt = 1'b0;
            i_nxt     = '0;
            state_nxt = ST_C_ORD;
          end else begin
            walk2_nxt = 1'b0;
            v_nxt     = '0;
            state_nxt = ST_W_INIT;
          end
        end else begin
          d_raddr   = i_r[VW-1:0];
          state_nxt = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if (d_rdata != deg0_r) begin
          regular_nxt = 1'b0;
        end
        // keep the first vertex of least degree
        if (d_rdata < minv_r) begin
          minv_nxt = d_rdata;
          umin_nxt = i_r[VW-1:0];
        end
        i_nxt     = i_r + NW'(1);
        state_nxt = ST_S_RD;
      end
      ST_W_INIT: begin
        // v_r holds the start vertex here
        vis_nxt        = '0;
        vis_nxt[v_r]   = 1'b1;
        q_we           = 1'b1;
        q_waddr        = '0;
        q_wdata        = v_r;
        head_nxt       = '0;
        tail_nxt       = NW'(1);
        reached_nxt    = NW'(1);
        state_nxt      = ST_W_POP;
      end
      ST_W_POP: begin
        if (head_r == tail_r) begin
          i_nxt = '0;
          if (walk2_r) begin
            smart_nxt = 1'b1;
            state_nxt = ST_C_ORD;
          end else if (reached_r == n_act) begin
            walk2_nxt = 1'b1;
            v_nxt     = umin_r;
            state_nxt = ST_W_INIT;
          end else begin
            smart_nxt = 1'b0;
            state_nxt = ST_C_ORD;
          end
        end else begin
          head_nxt  = head_r + NW'(1);
          state_nxt = ST_W_POPD;
        end
      end
      ST_W_POPD: begin
        v_nxt     = q_rdata;
        e_nxt     = '0;
        state_nxt = ST_W_RD;
      end
      ST_W_RD: begin
        if (e_r == ecnt_r) begin
          state_nxt = ST_W_POP;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = ST_W_EDGE;
        end
      end
      ST_W_EDGE: begin
        // at most one new vertex per edge: both sides match only on a self-loop
        priority if (rvalid && (ra == v_r) && !vis_r[rb]) begin
          vis_nxt[rb] = 1'b1;
          q_wdata     = rb;
          q_we        = (tail_r < NW'(MAX_VERTICES));
          tail_nxt    = q_we ? tail_r + NW'(1) : tail_r;
          reached_nxt = reached_r + NW'(1);
        end else if (rvalid && (rb == v_r) && !vis_r[ra]) begin
          vis_nxt[ra] = 1'b1;
          q_wdata     = ra;
          q_we        = (tail_r < NW'(MAX_VERTICES));
          tail_nxt    = q_we ? tail_r + NW'(1) : tail_r;
          reached_nxt = reached_r + NW'(1);
        end else begin
        end
        state_nxt = ST_W_RD;
      end
      ST_C_ORD: begin
        if (i_r == n_act) begin
          i_nxt     = '0;
          state_nxt = ST_O_RD;
        end else if (smart_r) begin
          // discovery order read back to front
          q_raddr   = VW'(n_act - NW'(1) - i_r);
          state_nxt = ST_C_ORDD;
        end else begin
          v_nxt     = i_r[VW-1:0];
          e_nxt     = '0;
          used_nxt  = '0;
          state_nxt = ST_C_RD;
        end
      end
      ST_C_ORDD: begin
        v_nxt     = q_rdata;
        e_nxt     = '0;
        used_nxt  = '0;
        state_nxt = ST_C_RD;
      end
      ST_C_RD: begin
        if (e_r == ecnt_r) begin
          c_nxt     = '0;
          state_nxt = ST_C_PICK;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = ST_C_EDGE;
        end
      end
      ST_C_EDGE: begin
        ea_nxt    = ra;
        eb_nxt    = rb;
        ev_nxt    = rvalid;
        col_raddr = rb;
        state_nxt = ST_C_CB;
      end
      ST_C_CB: begin
        if (ev_r && (ea_r == v_r) && cv_r) begin
          used_nxt[col_rdata] = 1'b1;
        end
        col_raddr = ea_r;
        state_nxt = ST_C_CA;
      end
      ST_C_CA: begin
        if (ev_r && (eb_r == v_r) && cv_r) begin
          used_nxt[col_rdata] = 1'b1;
        end
        state_nxt = ST_C_RD;
      end
      ST_C_PICK: begin
        if ((c_r != VW'(MAX_VERTICES - 1)) && used_r[c_r]) begin
          c_nxt = c_r + VW'(1);
        end else begin
          col_we        = 1'b1;
          cvld_nxt[v_r] = 1'b1;
          i_nxt         = i_r + NW'(1);
          state_nxt     = ST_C_ORD;
        end
      end
      ST_O_RD: begin
        col_raddr = i_r[VW-1:0];
        state_nxt = ST_O_LD;
      end
      ST_O_LD: begin
        out_valid_nxt  = 1'b1;
        out_vertex_nxt = i_r[VW-1:0];
        out_color_nxt  = cv_r ? col_rdata : '0;
        out_last_nxt   = (i_r + NW'(1) == n_act);
        state_nxt      = ST_O_WAIT;
      end
      ST_O_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // graph cleared, count register kept
            ecnt_nxt  = '0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + NW'(1);
            state_nxt = ST_O_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_vertex      = out_vertex_r;
  assign out_color       = out_color_r;
  assign out_last_vertex = out_last_r;

`ifndef SYNTHESIS
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_O_WAIT))
    else $error("result beat outside output wait");
  a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= ECW'(MAX_EDGES))
    else $error("edge count past store depth");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W_POP || state_r == ST_W_RD) |-> (head_r <= tail_r))
    else $error("discovery queue read past tail");
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_O_WAIT && !out_stall && out_last_r) |=> (ecnt_r == '0))
    else $error("graph not cleared after last result");
`endif

endmodule
